// File: hdl/dpsa_pkg.sv
// shared types and constants for the int16 dot product shift accumulate block
`default_nettype none

package dpsa_pkg;

    localparam int LANES_DEF    = 4;
    localparam int QDEPTH_DEF   = 4;
    localparam int LANE_W       = 16;
    localparam int SUM_W        = 32;
    localparam int SHIFT_W      = 5;
    localparam int C_W          = 16;
    localparam int USED_W       = 3;
    localparam int S_TDATA_W    = 152;
    localparam int M_TDATA_W    = 16;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // register index decoded from paddr[2]
    localparam logic REG_SHIFT_AMOUNT = 1'b0;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last;
        logic [C_W-1:0]   c_old;
    } q_entry_t;

endpackage

`default_nettype wire

// File: hdl/int16_dot_product_shift_accumulate.sv
// top level: int16 dot product with shifted accumulate into one c element
// throughput: one transaction per cycle while the queue and the output do not hold
// s_tready low, set by the lane multipliers and the running-sum adder
// c_new path after tlast: front s1 and s2 registers, queue, result and output registers
// reset: running sum cleared, shift_amount zero, queue and output stages empty
`default_nettype none

module int16_dot_product_shift_accumulate #(
    parameter int LANES  = dpsa_pkg::LANES_DEF,
    parameter int QDEPTH = dpsa_pkg::QDEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // a_lanes[63:0], b_lanes[127:64], lanes_used[130:128], c_old[146:131]
    input  wire logic [dpsa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // c_new[15:0]
    output logic [dpsa_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dpsa_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [dpsa_pkg::PDATA_W-1:0]     pwdata,
    output logic [dpsa_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    import dpsa_pkg::*;

    localparam int FIELD_W = 4 * LANE_W;

    logic [SHIFT_W-1:0] shift_amount_reg;
    logic [SHIFT_W-1:0] shift_amount_next;
    logic               cfg_write;
    logic               front_valid;
    logic               front_ready;
    q_entry_t           front_entry;
    logic               q_valid;
    logic               q_pop;
    q_entry_t           q_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == REG_SHIFT_AMOUNT);
    assign shift_amount_next = cfg_write ? pwdata[SHIFT_W-1:0] : shift_amount_reg;
    assign prdata = (paddr[2] == REG_SHIFT_AMOUNT)
                  ? {{(PDATA_W-SHIFT_W){1'b0}}, shift_amount_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_amount_reg <= '0;
        end
        else
        begin
            shift_amount_reg <= shift_amount_next;
        end
    end

    dpsa_front #(
        .LANES (LANES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .a_lanes    (s_tdata[LANES*LANE_W-1:0]),
        .b_lanes    (s_tdata[FIELD_W +: LANES*LANE_W]),
        .lanes_used (s_tdata[2*FIELD_W +: USED_W]),
        .last_pair  (s_tlast),
        .c_old      (s_tdata[2*FIELD_W+USED_W +: C_W]),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_entry  (front_entry)
    );

    dpsa_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_entry  (front_entry),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_entry (q_entry)
    );

    dpsa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .shift_amount (shift_amount_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (q_entry),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .c_new        (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/dpsa_front.sv
// front end: lane products and per-transaction partial sum
`default_nettype none

module dpsa_front #(
    parameter int LANES = dpsa_pkg::LANES_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [LANES*dpsa_pkg::LANE_W-1:0]     a_lanes,
    input  wire logic [LANES*dpsa_pkg::LANE_W-1:0]     b_lanes,
    input  wire logic [dpsa_pkg::USED_W-1:0]           lanes_used,
    input  wire logic                                  last_pair,
    input  wire logic [dpsa_pkg::C_W-1:0]              c_old,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output dpsa_pkg::q_entry_t                         out_entry
);

    import dpsa_pkg::*;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic signed [SUM_W-1:0] prod_reg [LANES];
    logic                    s1_last_reg;
    logic [C_W-1:0]          s1_c_old_reg;
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    q_entry_t                s2_entry_reg;
    q_entry_t                s2_entry_next;
    logic                    s1_ready;
    logic                    s2_ready;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_entry = s2_entry_reg;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // lanes at or beyond lanes_used contribute zero
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (s1_ready && in_valid)
            begin
                if (USED_W'(i) < lanes_used)
                begin
                    prod_reg[i] <= $signed(a_lanes[i*LANE_W +: LANE_W])
                                 * $signed(b_lanes[i*LANE_W +: LANE_W]);
                end
                else
                begin
                    prod_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_last_reg  <= last_pair;
            s1_c_old_reg <= c_old;
        end
    end

    always_comb
    begin
        s2_entry_next.sum   = '0;
        s2_entry_next.last  = s1_last_reg;
        s2_entry_next.c_old = s1_c_old_reg;
        for (int i = 0; i < LANES; i++)
        begin
            s2_entry_next.sum = s2_entry_next.sum + prod_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_entry_reg <= s2_entry_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dpsa_queue.sv
// short fifo between front end and accumulator
`default_nettype none

module dpsa_queue #(
    parameter int DEPTH = dpsa_pkg::QDEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire dpsa_pkg::q_entry_t in_entry,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output dpsa_pkg::q_entry_t      out_entry
);

    import dpsa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// File: hdl/dpsa_back.sv
// back end: running sum, shift, c update and output register
`default_nettype none

module dpsa_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [dpsa_pkg::SHIFT_W-1:0]   shift_amount,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  wire dpsa_pkg::q_entry_t             q_entry,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [dpsa_pkg::C_W-1:0]            c_new
);

    import dpsa_pkg::*;

    logic [SUM_W-1:0]        acc_reg;
    logic [SUM_W-1:0]        acc_next;
    logic [SUM_W-1:0]        total;
    logic                    r_valid_reg;
    logic                    r_valid_next;
    logic [SUM_W-1:0]        r_total_reg;
    logic [C_W-1:0]          r_c_old_reg;
    logic                    o_valid_reg;
    logic                    o_valid_next;
    logic [C_W-1:0]          o_c_new_reg;
    logic [C_W-1:0]          o_c_new_next;
    logic signed [SUM_W-1:0] shifted;
    logic                    o_ready;
    logic                    r_ready;
    logic                    r_load;
    logic                    o_load;

    assign o_ready = !o_valid_reg || out_ready;
    assign r_ready = !r_valid_reg || o_ready;
    assign q_pop   = q_valid && (!q_entry.last || r_ready);
    assign r_load  = q_pop && q_entry.last;
    assign o_load  = r_valid_reg && o_ready;

    assign total    = acc_reg + q_entry.sum;
    assign acc_next = q_pop ? (q_entry.last ? '0 : total) : acc_reg;

    assign r_valid_next = r_load ? 1'b1 : (o_load ? 1'b0 : r_valid_reg);
    assign o_valid_next = o_load ? 1'b1 : (out_ready ? 1'b0 : o_valid_reg);

    assign shifted      = $signed(r_total_reg) >>> shift_amount;
    assign o_c_new_next = r_c_old_reg + shifted[C_W-1:0];

    assign out_valid = o_valid_reg;
    assign c_new     = o_c_new_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            r_valid_reg <= r_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_load)
        begin
            r_total_reg <= total;
            r_c_old_reg <= q_entry.c_old;
        end
        if (o_load)
        begin
            o_c_new_reg <= o_c_new_next;
        end
    end

    a_last_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        r_load |=> r_valid_reg)
        else $error("final transaction did not reach result stage");

    a_last_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        r_load |=> acc_reg == '0)
        else $error("running sum not cleared after final transaction");

endmodule

`default_nettype wire

// File: verif/dpsa_result_checker.sv
// result checker: predicts c_new from the input stream and compares the output stream

module dpsa_result_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [dpsa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [dpsa_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dpsa_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [dpsa_pkg::PDATA_W-1:0]     pwdata,
    input  wire logic [dpsa_pkg::PDATA_W-1:0]     prdata,
    input  wire logic                             pready,
    output int                                    error_total,
    output int                                    c_pending
);

    import dpsa_pkg::*;

    localparam int PACK_W = LANES_DEF * LANE_W;
    localparam int PAD_W  = S_TDATA_W - 2 * PACK_W - USED_W - C_W;

    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [C_W-1:0]    c_old;
        logic [USED_W-1:0] used;
        logic [PACK_W-1:0] b;
        logic [PACK_W-1:0] a;
    } s_word_t;

    logic [SUM_W-1:0]   dot_sum;
    logic [SHIFT_W-1:0] shift_cfg;
    logic [C_W-1:0]     c_new_expected[$];
    int                 errors = 0;

    initial error_total = 0;
    initial c_pending = 0;

    function automatic logic [SUM_W-1:0] lane_dot(input logic [PACK_W-1:0] a,
                                                  input logic [PACK_W-1:0] b,
                                                  input logic [USED_W-1:0] used);
        logic [SUM_W-1:0]        acc;
        logic signed [SUM_W-1:0] prod;
        int                      n;
        acc = '0;
        n = (used > LANES_DEF) ? LANES_DEF : int'(used);
        for (int i = 0; i < n; i++)
        begin
            prod = $signed(a[LANE_W*i +: LANE_W]) * $signed(b[LANE_W*i +: LANE_W]);
            acc = acc + prod;
        end
        return acc;
    endfunction

    function automatic logic [C_W-1:0] shifted_update(input logic [SUM_W-1:0] sum,
                                                      input logic [SHIFT_W-1:0] sh,
                                                      input logic [C_W-1:0] c_old);
        logic signed [SUM_W-1:0] q;
        q = $signed(sum) >>> sh;
        return c_old + q[C_W-1:0];
    endfunction

    task automatic note_error(input string what);
        if (errors < 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        s_word_t        word;
        logic [C_W-1:0] want;
        if (!rst_n)
        begin
            dot_sum = '0;
            shift_cfg = '0;
            c_new_expected.delete();
            c_pending <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_SHIFT_AMOUNT)
            begin
                if (pwrite)
                begin
                    shift_cfg = pwdata[SHIFT_W-1:0];
                end
                else if (prdata[SHIFT_W-1:0] !== shift_cfg)
                begin
                    note_error($sformatf("shift_amount read expected %0d, actual %0d",
                                         shift_cfg, prdata[SHIFT_W-1:0]));
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (c_new_expected.size() == 0)
                begin
                    note_error($sformatf("c_new %h with no transaction pending", m_tdata));
                end
                else
                begin
                    want = c_new_expected.pop_front();
                    if (m_tdata[C_W-1:0] !== want)
                    begin
                        note_error($sformatf("c_new expected %h, actual %h",
                                             want, m_tdata[C_W-1:0]));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                word = s_tdata;
                dot_sum = dot_sum + lane_dot(word.a, word.b, word.used);
                if (s_tlast)
                begin
                    c_new_expected.push_back(shifted_update(dot_sum, shift_cfg, word.c_old));
                    dot_sum = '0;
                end
            end
            c_pending <= c_new_expected.size();
        end
        error_total <= errors;
    end

endmodule

// File: verif/int16_dot_product_shift_accumulate_test.sv
// testbench top: stimulus, idling and verdict for the int16 dot product shift accumulate block

module int16_dot_product_shift_accumulate_test;

    import dpsa_pkg::*;

    localparam int PACK_W       = LANES_DEF * LANE_W;
    localparam int PAD_W        = S_TDATA_W - 2 * PACK_W - USED_W - C_W;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 238;
    localparam logic [PADDR_W-1:0] SHIFT_ADDR = {REG_SHIFT_AMOUNT, 2'b00};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int error_total;
    int c_pending;
    int cycle_count = 0;
    int rx_hold = 0;
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    int16_dot_product_shift_accumulate i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dpsa_result_checker i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .error_total (error_total),
        .c_pending   (c_pending)
    );

    // receiver drops m_tready in random bursts of random length while rx_stalls is set
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (rx_stalls && $urandom_range(0, 3) == 0)
        begin
            rx_hold <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic cfg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input logic [PACK_W-1:0] a, input logic [PACK_W-1:0] b,
                             input logic [USED_W-1:0] used, input logic last,
                             input logic [C_W-1:0] c_old);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{PAD_W{1'b0}}, c_old, used, b, a};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // waits for every pending c_new, then lets the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (c_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PACK_W-1:0] rand_lanes();
        logic [PACK_W-1:0] v;
        for (int i = 0; i < LANES_DEF; i++)
        begin
            case ($urandom_range(0, 7))
                0:       v[LANE_W*i +: LANE_W] = 16'h8000;
                1:       v[LANE_W*i +: LANE_W] = 16'h7fff;
                2:       v[LANE_W*i +: LANE_W] = 16'hffff;
                3:       v[LANE_W*i +: LANE_W] = 16'($urandom_range(0, 15));
                default: v[LANE_W*i +: LANE_W] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [USED_W-1:0] rand_used();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10)
        begin
            return USED_W'(LANES_DEF);
        end
        else if (r < 13)
        begin
            return USED_W'($urandom_range(1, LANES_DEF - 1));
        end
        else if (r == 13)
        begin
            return '0;
        end
        return USED_W'($urandom_range(LANES_DEF + 1, 7));
    endfunction

    task automatic run_random(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                send_item(rand_lanes(), rand_lanes(), rand_used(), k == len - 1,
                          C_W'($urandom));
            end
            sent += len;
        end
    endtask

    initial
    begin
        logic [SHIFT_W-1:0] shift_plan[PHASES];
        bit                 gap_plan[PHASES];
        bit                 stall_plan[PHASES];
        shift_plan = '{5'd31, 5'd1, 5'd16, 5'd0, 5'($urandom_range(2, 30)),
                       5'($urandom_range(0, 31))};
        gap_plan   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        stall_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_access(1'b1, SHIFT_ADDR, 32'd0);
        cfg_access(1'b0, SHIFT_ADDR, 32'd0);

        // sum overflow: four products of 2^30 wrap to zero
        send_item({4{16'h8000}}, {4{16'h8000}}, 3'd4, 1'b1, 16'h0000);
        // not last, c_old ignored; then a last with zero lanes
        send_item({4{16'h7fff}}, {4{16'h8000}}, 3'd4, 1'b0, 16'h1234);
        send_item('0, '0, 3'd0, 1'b1, 16'h7fff);
        send_item({4{16'hffff}}, {4{16'hffff}}, 3'd0, 1'b0, 16'h8000);
        send_item({4{16'hffff}}, {4{16'hffff}}, 3'd0, 1'b1, 16'h8000);
        // lanes beyond the count carry junk
        send_item({16'h7fff, 16'h8000, 16'h1234, 16'h0003},
                  {16'h7fff, 16'h7fff, 16'h5678, 16'hfffd}, 3'd1, 1'b1, 16'h8000);
        send_item({16'h7fff, 16'h8000, 16'h1234, 16'h0003},
                  {16'h7fff, 16'h7fff, 16'h5678, 16'hfffd}, 3'd2, 1'b1, 16'h7fff);
        send_item({16'h7fff, 16'h8000, 16'h1234, 16'h0003},
                  {16'h7fff, 16'h7fff, 16'h5678, 16'hfffd}, 3'd3, 1'b1, 16'h0001);
        // lane counts above four
        send_item({4{16'hffff}}, {4{16'h0001}}, 3'd5, 1'b0, 16'hffff);
        send_item({4{16'hffff}}, {4{16'h0001}}, 3'd6, 1'b0, 16'hffff);
        send_item({4{16'hffff}}, {4{16'h0001}}, 3'd7, 1'b1, 16'h7fff);
        // c_new wrap both ways
        send_item({4{16'h7fff}}, {4{16'h7fff}}, 3'd1, 1'b1, 16'h7fff);
        send_item({4{16'h8000}}, {4{16'h7fff}}, 3'd1, 1'b1, 16'h8000);
        // positive overflow across items
        send_item({4{16'h7fff}}, {4{16'h7fff}}, 3'd4, 1'b0, 16'h0000);
        send_item({4{16'h7fff}}, {4{16'h7fff}}, 3'd4, 1'b0, 16'h0000);
        send_item({4{16'h8000}}, {4{16'h8000}}, 3'd4, 1'b1, 16'h5555);
        send_item({4{16'h5555}}, {4{16'haaaa}}, 3'd4, 1'b1, 16'haaaa);
        send_item({4{16'haaaa}}, {4{16'h5555}}, 3'd4, 1'b1, 16'h5555);
        // left open so the sum carries over a register change
        send_item({4{16'h0100}}, {4{16'hff00}}, 3'd4, 1'b0, 16'h0000);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            cfg_access(1'b1, SHIFT_ADDR, PDATA_W'(shift_plan[p]));
            cfg_access(1'b0, SHIFT_ADDR, 32'd0);
            tx_gaps <= gap_plan[p];
            rx_stalls <= stall_plan[p];
            run_random(PHASE_ITEMS);
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        settle();
        if (error_total == 0 && c_pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
